// ===== src/srec_pkg.sv =====
`timescale 1ns / 1ps

package srec_pkg;

	localparam int ADDR_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 8;
	localparam int BPR_W   = 5;
	localparam int KIDX_W  = 9;

	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h41;

	localparam logic [ADDR_W-1:0] LIM_S1 = 32'h0000_FFFF;
	localparam logic [ADDR_W-1:0] LIM_S2 = 32'h00FF_FFFF;

	localparam logic REG_START_ADDRESS    = 1'b0;
	localparam logic REG_BYTES_PER_RECORD = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last_of_run;
		logic       end_of_file;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  dlen;
		logic              s9;
	} rec_cmd_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'd0, nib};
		end else begin
			c = CH_A + {4'd0, nib} - 8'd10;
		end
		return c;
	endfunction

endpackage

// ===== src/srec_ram.sv =====
`timescale 1ns / 1ps

module srec_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/srec_emitter.sv =====
`timescale 1ns / 1ps

module srec_emitter #(
	parameter int RD_AW = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  srec_pkg::rec_cmd_t  cmd,
	input  logic [15:0]         s9_addr,
	output logic                busy,
	output logic [RD_AW-1:0]    rd_idx,
	input  logic [7:0]          rd_data,
	output logic                result_valid,
	input  logic                result_ready,
	output srec_pkg::out_item_t result
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_S    = 6'b000010,
		ST_TYPE = 6'b000100,
		ST_HI   = 6'b001000,
		ST_LO   = 6'b010000,
		ST_NL   = 6'b100000
	} emit_state_t;

	emit_state_t state_q;

	logic                          out_valid_q;
	srec_pkg::out_item_t           out_q;
	logic [7:0]                    type_q;
	logic [2:0]                    alen_q;
	logic [srec_pkg::LEN_W-1:0]    dlen_q;
	logic [srec_pkg::ADDR_W-1:0]   addr_q;
	logic [srec_pkg::KIDX_W-1:0]   k_q;
	logic [7:0]                    cur_q;
	logic [7:0]                    sum_q;
	logic [RD_AW-1:0]              rd_idx_q;
	logic                          s9_pend_q;
	logic                          is_s9_q;

	logic                          emit_en;
	logic                          load;
	logic [srec_pkg::KIDX_W-1:0]   last_k;
	logic [srec_pkg::KIDX_W-1:0]   ld_k;
	logic [srec_pkg::KIDX_W-1:0]   alen9;
	logic [srec_pkg::KIDX_W-1:0]   dend9;
	logic [srec_pkg::KIDX_W-1:0]   adiff;
	logic                          is_ck;
	logic                          is_data;
	logic [7:0]                    addr_byte;
	logic [7:0]                    nb;
	logic [7:0]                    ch;
	logic [7:0]                    start_type;
	logic [2:0]                    start_alen;

	assign emit_en      = !out_valid_q || result_ready;
	assign busy         = (state_q != ST_IDLE);
	assign rd_idx       = rd_idx_q;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		alen9  = srec_pkg::KIDX_W'(alen_q);
		dend9  = alen9 + srec_pkg::KIDX_W'(dlen_q);
		last_k = dend9 + 9'd1;
		ld_k   = (state_q == ST_TYPE) ? '0 : k_q + 9'd1;
		is_ck  = ld_k > dend9;
		is_data = (ld_k > alen9) && !is_ck;
		adiff  = alen9 - ld_k;
		unique case (adiff[1:0])
			2'd0: addr_byte = addr_q[7:0];
			2'd1: addr_byte = addr_q[15:8];
			2'd2: addr_byte = addr_q[23:16];
			default: addr_byte = addr_q[31:24];
		endcase
		priority if (ld_k == '0) begin
			nb = last_k[7:0];
		end else if (ld_k <= alen9) begin
			nb = addr_byte;
		end else if (is_data) begin
			nb = rd_data;
		end else begin
			nb = ~sum_q;
		end
	end

	always_comb begin
		if (cmd.addr <= srec_pkg::LIM_S1) begin
			start_type = srec_pkg::CH_ONE;
			start_alen = 3'd2;
		end else if (cmd.addr <= srec_pkg::LIM_S2) begin
			start_type = srec_pkg::CH_TWO;
			start_alen = 3'd3;
		end else begin
			start_type = srec_pkg::CH_THREE;
			start_alen = 3'd4;
		end
	end

	always_comb begin
		unique case (state_q)
			ST_S:    ch = srec_pkg::CH_S;
			ST_TYPE: ch = type_q;
			ST_HI:   ch = srec_pkg::hex_char(cur_q[7:4]);
			ST_LO:   ch = srec_pkg::hex_char(cur_q[3:0]);
			ST_NL:   ch = srec_pkg::CH_NL;
			default: ch = srec_pkg::CH_NL;
		endcase
	end

	assign load = emit_en && ((state_q == ST_TYPE) || ((state_q == ST_LO) && (k_q != last_k)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_en && state_q != ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (cmd.start) begin
					state_q <= ST_S;
				end
				ST_S: if (emit_en) begin
					state_q <= ST_TYPE;
				end
				ST_TYPE: if (emit_en) begin
					state_q <= ST_HI;
				end
				ST_HI: if (emit_en) begin
					state_q <= ST_LO;
				end
				ST_LO: if (emit_en) begin
					state_q <= (k_q == last_k) ? ST_NL : ST_HI;
				end
				ST_NL: if (emit_en) begin
					state_q <= s9_pend_q ? ST_S : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.start) begin
			addr_q    <= cmd.addr;
			dlen_q    <= cmd.dlen;
			s9_pend_q <= cmd.s9;
			is_s9_q   <= 1'b0;
			type_q    <= start_type;
			alen_q    <= start_alen;
			sum_q     <= '0;
			rd_idx_q  <= '0;
		end else if (emit_en) begin
			if (load) begin
				cur_q <= nb;
				k_q   <= ld_k;
				if (!is_ck) begin
					sum_q <= sum_q + nb;
				end
				if (is_data) begin
					rd_idx_q <= rd_idx_q + RD_AW'(1);
				end
			end
			if (state_q == ST_NL && s9_pend_q) begin
				addr_q    <= {16'd0, s9_addr};
				dlen_q    <= '0;
				s9_pend_q <= 1'b0;
				is_s9_q   <= 1'b1;
				type_q    <= srec_pkg::CH_NINE;
				alen_q    <= 3'd2;
				sum_q     <= '0;
				rd_idx_q  <= '0;
			end
		end
		if (emit_en && state_q != ST_IDLE) begin
			out_q.out_char    <= ch;
			out_q.last_of_run <= (state_q == ST_NL) && !s9_pend_q;
			out_q.end_of_file <= (state_q == ST_NL) && is_s9_q;
		end
	end

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> state_q == ST_IDLE)
		else $error("record start while a record is still being emitted");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HI || state_q == ST_LO) |-> k_q <= last_k)
		else $error("byte index ran past the checksum");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HI || state_q == ST_LO) |-> srec_pkg::LEN_W'(rd_idx_q) <= dlen_q
			|| rd_idx_q == '0)
		else $error("buffer read index beyond record length");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.end_of_file) |-> (out_q.last_of_run
			&& out_q.out_char == srec_pkg::CH_NL))
		else $error("end of file flagged on a character that does not close the run");

endmodule

// ===== src/s_record_stream_encoder_top.sv =====
`timescale 1ns / 1ps

// S-record encoder: bytes are buffered in a small RAM and, when a record fills
// (bytes_per_record) or a byte marked end_of_stream arrives, one S1/S2/S3 line
// is sent out one ASCII character per transaction, followed after the final
// byte by an S9 line carrying the low 16 bits of start_address. A byte that
// completes no record leaves the input ready for the next byte. A byte that
// completes a record holds the input while the emitter sequencer sends the
// line, and the S9 line after the final byte, one character per cycle unless
// result_ready stalls it. Characters stall on result_ready without loss.

module s_record_stream_encoder_top #(
	parameter int MAX_RECORD_BYTES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  srec_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output srec_pkg::out_item_t result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
	localparam int FW = $clog2(MAX_RECORD_BYTES + 1);

	logic [srec_pkg::ADDR_W-1:0] start_q;
	logic [srec_pkg::BPR_W-1:0]  bpr_q;
	logic [srec_pkg::ADDR_W-1:0] stream_addr_q;
	logic [FW-1:0]               fill_q;
	logic                        in_stream_q;

	logic                        busy;
	logic                        accept;
	logic                        cfg_wr;
	logic [srec_pkg::ADDR_W-1:0] base_addr;
	logic [FW-1:0]               fill_b;
	logic [FW-1:0]               fill_n;
	logic [srec_pkg::LEN_W-1:0]  lim;
	logic                        emit;
	srec_pkg::rec_cmd_t          cmd;
	logic [AW-1:0]               rd_idx;
	logic [7:0]                  rd_data;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign item_ready = !busy;
	assign accept     = item_valid && item_ready;

	always_comb begin
		unique case (paddr[2])
			srec_pkg::REG_START_ADDRESS:    prdata = start_q;
			srec_pkg::REG_BYTES_PER_RECORD: prdata = {27'd0, bpr_q};
			default:                        prdata = start_q;
		endcase
	end

	always_comb begin
		base_addr = in_stream_q ? stream_addr_q : start_q;
		fill_b    = in_stream_q ? fill_q : '0;
		fill_n    = fill_b + FW'(1);
		priority if (bpr_q == '0) begin
			lim = 8'd1;
		end else if (srec_pkg::LEN_W'(bpr_q) > srec_pkg::LEN_W'(MAX_RECORD_BYTES)) begin
			lim = srec_pkg::LEN_W'(MAX_RECORD_BYTES);
		end else begin
			lim = srec_pkg::LEN_W'(bpr_q);
		end
		emit = (srec_pkg::LEN_W'(fill_n) >= lim) || item.end_of_stream;
	end

	always_comb begin
		cmd.start = accept && emit;
		cmd.addr  = base_addr;
		cmd.dlen  = srec_pkg::LEN_W'(fill_n);
		cmd.s9    = item.end_of_stream;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q       <= '0;
			bpr_q         <= 5'd16;
			stream_addr_q <= '0;
			fill_q        <= '0;
			in_stream_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					srec_pkg::REG_START_ADDRESS:    start_q <= pwdata;
					srec_pkg::REG_BYTES_PER_RECORD: bpr_q   <= pwdata[4:0];
					default:                        start_q <= pwdata;
				endcase
			end
			if (accept) begin
				in_stream_q <= !item.end_of_stream;
				if (emit) begin
					fill_q        <= '0;
					stream_addr_q <= base_addr + srec_pkg::ADDR_W'(fill_n);
				end else begin
					fill_q        <= fill_n;
					stream_addr_q <= base_addr;
				end
			end
		end
	end

	srec_ram #(
		.WIDTH (srec_pkg::BYTE_W),
		.DEPTH (MAX_RECORD_BYTES),
		.ADDR_W(AW)
	) u_buf (
		.clk  (clk),
		.we   (accept),
		.waddr(fill_b[AW-1:0]),
		.wdata(item.data_byte),
		.raddr(rd_idx),
		.rdata(rd_data)
	);

	srec_emitter #(
		.RD_AW(AW)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.s9_addr     (start_q[15:0]),
		.busy        (busy),
		.rd_idx      (rd_idx),
		.rd_data     (rd_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	a_fill_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		srec_pkg::LEN_W'(fill_q) < srec_pkg::LEN_W'(MAX_RECORD_BYTES))
		else $error("fill count reached buffer depth");

	a_eos_starts_record: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.end_of_stream) |=> (busy && !in_stream_q))
		else $error("final byte did not start a record");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(accept))
		else $error("emitter started without an accepted byte");

endmodule
